[src/tpsm_pkg.sv]
// Package for the tribonacci prefix-sum block: widths, reset modulus,
// register map and companion matrix. No dependencies.
package tpsm_pkg;
    localparam int unsigned VAL_W  = 51;
    localparam int unsigned OUT_W  = 50;
    localparam int unsigned CFG_W  = 64;
    localparam int unsigned ADDR_W = 1;
    localparam logic [VAL_W-1:0] MOD_RESET = 51'd1000000000000007;
    localparam logic [VAL_W-1:0] MOD_MAX   = 51'd1125899906842624;
    localparam logic [ADDR_W-1:0] REG_MODULUS = 1'b0;

    typedef logic [VAL_W-1:0] t_val;
    typedef t_val t_mat [16];

    // companion matrix entry, row-major element index
    function automatic t_val comp_entry(input logic [3:0] idx);
        t_val v;
        v = '0;
        case (idx)
            4'd0, 4'd1, 4'd5, 4'd6, 4'd7, 4'd9, 4'd14: v = t_val'(1);
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

[src/tpsm_stream_if.sv]
// Valid/ready stream interface carrying one payload word.
// Depends on nothing.
interface tpsm_stream_if #(parameter int unsigned W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/tribonacci_prefix_sum_mod.sv]
// Top level of the tribonacci prefix-sum block: APB modulus register,
// matrix power sequencer over the bit-serial multiplier. Depends on tpsm_pkg,
// tpsm_stream_if, tpsm_mulmod.
// Sequence: per index bit, a step that picks the product, then one or two 4x4
//   matrix products of 64 multiplies, each issued, started, run through 51
//   double-and-add steps, flagged done and accumulated. Index 0 or modulus
//   below 2 gives the result on the cycle after accept. One item at a time;
//   the shared multiplier sets the rate. Reset loads modulus 10^15+7, clears
//   control.
module tribonacci_prefix_sum_mod #(
    parameter int unsigned INDEX_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tpsm_stream_if.sink                   s_in,
    tpsm_stream_if.source                 m_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [tpsm_pkg::CFG_W-1:0]    pwdata,
    output logic [tpsm_pkg::CFG_W-1:0]    prdata,
    output logic                          pready
);
    import tpsm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_MUL = 3'd1, ST_WAIT = 3'd2,
                           ST_ACC = 3'd3, ST_NEXT = 3'd4, ST_FIN = 3'd5, ST_OUT = 3'd6;
    localparam int unsigned BW = $clog2(INDEX_BITS + 1);

    t_val r_mod;
    t_val w_m;
    logic [2:0] r_st;
    logic [INDEX_BITS-1:0] r_e;
    logic [BW-1:0] r_bit;
    logic r_sq;          // 0: res*=pw, 1: pw*=pw
    logic [5:0] r_ijk;   // {i,j,k}
    t_val r_res [16];
    t_val r_pw  [16];
    t_val r_tmp [16];
    t_val r_s;
    logic [OUT_W-1:0] r_out;
    logic r_start;

    // modulus register; values above 2^50 saturate
    assign pready = 1'b1;
    assign prdata = CFG_W'(r_mod);
    assign w_m = (r_mod > MOD_MAX) ? MOD_MAX : r_mod;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mod <= MOD_RESET;
        else if (psel && penable && pwrite && paddr == REG_MODULUS)
            r_mod <= pwdata[VAL_W-1:0];
    end

    // operand select for the shared multiplier
    logic [3:0] w_ai, w_bi, w_ci;
    t_val w_x, w_y, w_p;
    logic w_done;
    logic [VAL_W:0] w_sum;
    t_val w_sm;
    assign w_ai = {r_ijk[5:4], r_ijk[1:0]};
    assign w_bi = {r_ijk[1:0], r_ijk[3:2]};
    assign w_ci = r_ijk[5:2];
    assign w_x  = r_sq ? r_pw[w_ai] : r_res[w_ai];
    assign w_y  = r_pw[w_bi];
    assign w_sum = {1'b0, r_s} + {1'b0, w_p};
    assign w_sm  = (w_sum >= {1'b0, w_m}) ? t_val'(w_sum - {1'b0, w_m}) : w_sum[VAL_W-1:0];

    tpsm_mulmod u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_x(w_x), .i_y(w_y), .i_mod(w_m), .o_done(w_done), .o_prod(w_p)
    );

    // final weighting: res00 + res02 + 2*res01
    logic [VAL_W+1:0] w_f;
    logic [VAL_W+1:0] w_f1;
    assign w_f  = {2'b0, r_res[0]} + {2'b0, r_res[2]} + {1'b0, r_res[1], 1'b0};
    assign w_f1 = (w_f >= {1'b0, w_m, 1'b0}) ? w_f - {1'b0, w_m, 1'b0} : w_f;

    assign s_in.ready   = (r_st == ST_IDLE);
    assign m_out.valid  = (r_st == ST_OUT);
    assign m_out.data   = r_out;

    always_ff @(posedge i_clk) begin
        r_start <= 1'b0;
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            case (r_st)
                ST_IDLE: if (s_in.valid) begin
                    r_e   <= s_in.data[INDEX_BITS-1:0] - INDEX_BITS'(1);
                    r_bit <= '0;
                    for (int q = 0; q < 16; q++) begin
                        r_res[q] <= (q % 5 == 0) ? t_val'(1) : '0;
                        r_pw[q]  <= comp_entry(4'(q));
                    end
                    if (s_in.data[INDEX_BITS-1:0] == '0 || w_m < t_val'(2)) begin
                        r_out <= '0;
                        r_st  <= ST_OUT;
                    end else begin
                        r_st <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    // pick the product for this bit, or advance
                    if (r_bit == BW'(INDEX_BITS)) r_st <= ST_FIN;
                    else begin
                        r_sq <= !r_e[0];
                        r_ijk <= '0;
                        r_s <= '0;
                        r_st <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_start <= 1'b1;
                    r_st    <= ST_WAIT;
                end
                ST_WAIT: if (w_done) begin
                    r_s  <= w_sm;
                    r_st <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_ijk[1:0] == 2'd3) begin
                        r_tmp[w_ci] <= r_s;
                        r_s <= '0;
                    end
                    if (r_ijk == 6'h3f) begin
                        for (int q = 0; q < 16; q++) begin
                            if (r_sq) r_pw[q] <= (q == 15) ? r_s : r_tmp[q];
                            else      r_res[q] <= (q == 15) ? r_s : r_tmp[q];
                        end
                        if (r_sq) begin
                            r_e   <= r_e >> 1;
                            r_bit <= r_bit + BW'(1);
                            r_st  <= ST_NEXT;
                        end else begin
                            r_sq  <= 1'b1;
                            r_ijk <= '0;
                            r_st  <= ST_MUL;
                        end
                    end else begin
                        r_ijk <= r_ijk + 6'd1;
                        r_st  <= ST_MUL;
                    end
                end
                ST_FIN: begin
                    r_out <= (w_f1 >= {2'b0, w_m}) ? OUT_W'(w_f1 - {2'b0, w_m})
                                                   : OUT_W'(w_f1);
                    r_st  <= ST_OUT;
                end
                ST_OUT: if (m_out.ready) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_IDLE |-> !s_in.ready)
        else $error("accepted while busy");
    a_start_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> r_st == ST_WAIT)
        else $error("multiplier start out of sequence");
endmodule

[src/tpsm_mulmod.sv]
// Bit-serial modular multiplier: one double-and-add step per cycle.
// Depends on tpsm_pkg.
module tpsm_mulmod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tpsm_pkg::t_val  i_x,
    input  tpsm_pkg::t_val  i_y,
    input  tpsm_pkg::t_val  i_mod,
    output logic            o_done,
    output tpsm_pkg::t_val  o_prod
);
    import tpsm_pkg::*;

    logic [5:0] r_cnt, n_cnt;
    logic       r_busy, n_busy;
    logic       r_done;
    t_val       r_acc, n_acc, r_y, n_y;
    logic [VAL_W:0] w_dbl, w_add;
    t_val       w_d;

    assign w_dbl = {1'b0, r_acc} + {1'b0, r_acc};
    assign w_d   = (w_dbl >= {1'b0, i_mod}) ? t_val'(w_dbl - {1'b0, i_mod}) : w_dbl[VAL_W-1:0];
    assign w_add = {1'b0, w_d} + {1'b0, i_x};

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_acc  = r_acc;
        n_y    = r_y;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'(VAL_W - 1);
            n_acc  = '0;
            n_y    = i_y;
        end else if (r_busy) begin
            // shift the multiplier msb-first, one digit per cycle
            if (r_y[VAL_W-1])
                n_acc = (w_add >= {1'b0, i_mod}) ? t_val'(w_add - {1'b0, i_mod})
                                                 : w_add[VAL_W-1:0];
            else
                n_acc = w_d;
            n_y   = {r_y[VAL_W-2:0], 1'b0};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == '0) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            // flag the cycle after the last step, once the product is registered
            r_done <= r_busy && !n_busy;
        end
        r_acc <= n_acc;
        r_y   <= n_y;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

[verif/tb_tribonacci_prefix_sum_mod.sv]
// Self-checking testbench for tribonacci_prefix_sum_mod: stream driver,
// result monitor, APB modulus writes and a matrix-power predictor.
// Depends on tpsm_pkg, tpsm_stream_if and the block itself.
`timescale 1ns / 1ps

module tb_tribonacci_prefix_sum_mod;
    import tpsm_pkg::*;

    localparam int unsigned IDX_W      = 32;
    localparam int unsigned WATCH_MAX  = 1000000;
    localparam int unsigned HOLD_LEN   = 40000;
    localparam int unsigned HOLD_AFTER = 30;

    typedef logic [15:0][VAL_W-1:0] t_mat4;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata, prdata;

    tpsm_stream_if #(.W(IDX_W)) idx_if ();
    tpsm_stream_if #(.W(OUT_W)) sum_if ();

    tribonacci_prefix_sum_mod #(.INDEX_BITS(IDX_W)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (idx_if.sink),
        .m_out   (sum_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock: 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [IDX_W-1:0] idx_pending [$];   // indices waiting to be offered
    logic [OUT_W-1:0] sum_expected [$];  // predicted sums, oldest first
    logic [VAL_W-1:0] mod_shadow;        // mirror of the modulus register
    logic             no_gaps;           // phase without idling
    int unsigned      fail_cnt  = 0;
    int unsigned      idx_beats = 0;
    int unsigned      sum_beats = 0;

    // ------------------------------------------------------------------
    // Predictor: modular double-and-add product, 4x4 matrix product and
    // square-and-multiply over the index bits.
    // ------------------------------------------------------------------
    function automatic longint unsigned mod_add(longint unsigned a, longint unsigned b,
                                                longint unsigned m);
        longint unsigned s;
        s = a + b;
        return (s >= m) ? s - m : s;
    endfunction

    function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned m);
        longint unsigned acc;
        acc = 0;
        for (int bit_i = 50; bit_i >= 0; bit_i--) begin
            acc = mod_add(acc, acc, m);
            if (b[bit_i])
                acc = mod_add(acc, a, m);
        end
        return acc;
    endfunction

    function automatic t_mat4 mat_mul(t_mat4 a, t_mat4 b, longint unsigned m);
        t_mat4 t;
        longint unsigned s;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                s = 0;
                for (int k = 0; k < 4; k++)
                    s = mod_add(s, mod_mul(a[r*4+k], b[k*4+c], m), m);
                t[r*4+c] = VAL_W'(s);
            end
        end
        return t;
    endfunction

    function automatic logic [OUT_W-1:0] tri_prefix_sum(logic [IDX_W-1:0] n,
                                                        logic [VAL_W-1:0] mod_reg);
        longint unsigned m, r;
        logic [IDX_W-1:0] e;
        t_mat4 acc, pw;
        m = 64'(mod_reg);
        // clamp oversize moduli to 2^50
        if (m > 64'(MOD_MAX))
            m = 64'(MOD_MAX);
        if (n == '0 || m < 2)
            return '0;
        e = n - 1'b1;
        acc = '0;
        pw  = '0;
        for (int i = 0; i < 4; i++)
            acc[i*5] = VAL_W'(1);
        // companion matrix rows {1,1,0,0} {0,1,1,1} {0,1,0,0} {0,0,1,0}
        pw[0] = VAL_W'(1); pw[1] = VAL_W'(1); pw[5] = VAL_W'(1); pw[6] = VAL_W'(1);
        pw[7] = VAL_W'(1); pw[9] = VAL_W'(1); pw[14] = VAL_W'(1);
        for (int b = 0; b < IDX_W; b++) begin
            if (e[b])
                acc = mat_mul(acc, pw, m);
            pw = mat_mul(pw, pw, m);
        end
        // weight the first row with the start vector (1, 2, 1, 0)
        r = mod_add(acc[0], acc[2], m);
        r = mod_add(r, mod_add(acc[1], acc[1], m), m);
        return OUT_W'(r);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer pending indices, hold each beat until it is taken.
    // ------------------------------------------------------------------
    int unsigned idx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idx_if.valid <= 1'b0;
            idx_if.data  <= '0;
            idx_gap      = 0;
        end else begin
            if (idx_if.valid && idx_if.ready) begin
                // predict with the modulus in force for this beat
                sum_expected.push_back(tri_prefix_sum(idx_if.data, mod_shadow));
                void'(idx_pending.pop_front());
                idx_beats++;
                idx_gap = no_gaps ? 0 : gap_len();
            end
            if (idx_if.valid && !idx_if.ready) begin
                // hold the beat unchanged
            end else if (idx_gap > 0) begin
                idx_gap--;
                idx_if.valid <= 1'b0;
            end else if (idx_pending.size() > 0) begin
                idx_if.valid <= 1'b1;
                idx_if.data  <= idx_pending[0];
            end else begin
                idx_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, one long hold-off, result check.
    // ------------------------------------------------------------------
    int unsigned sum_stall = 0;
    bit          hold_done = 1'b0;
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            sum_if.ready <= 1'b0;
        end else begin
            if (sum_if.valid && sum_if.ready) begin
                sum_beats++;
                if (sum_expected.size() == 0) begin
                    $display("%0t: unexpected sum: expected none, actual %0d",
                             $time, sum_if.data);
                    fail_cnt++;
                end else begin
                    want = sum_expected.pop_front();
                    if (sum_if.data !== want) begin
                        $display("%0t: prefix_sum mismatch: expected %0d, actual %0d",
                                 $time, want, sum_if.data);
                        fail_cnt++;
                    end
                end
                // drop ready for a long stretch once, while indices keep coming
                if (!hold_done && sum_beats == HOLD_AFTER) begin
                    hold_done = 1'b1;
                    sum_stall = HOLD_LEN;
                end else begin
                    sum_stall = no_gaps ? 0 : gap_len();
                end
            end
            if (sum_stall > 0) begin
                sum_stall--;
                sum_if.ready <= 1'b0;
            end else begin
                sum_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run after too many cycles without any beat.
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((idx_if.valid && idx_if.ready) || (sum_if.valid && sum_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_MAX) begin
            $display("%0t: watchdog expired, %0d sums outstanding", $time,
                     sum_expected.size());
            $display("tb_tribonacci_prefix_sum_mod: FAIL");
            $finish;
        end
    end

    // APB write: setup cycle, access cycle, complete on pready.
    task automatic write_modulus(logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MODULUS;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mod_shadow = value[VAL_W-1:0];
    endtask

    // Mostly small indices keep the run short; a few span all 32 bits.
    function automatic logic [IDX_W-1:0] rand_index();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 70) return IDX_W'($urandom_range(0, 40));
        if (p < 92) return IDX_W'($urandom_range(41, 4095));
        return IDX_W'($urandom());
    endfunction

    task automatic wait_drained();
        while (idx_pending.size() > 0 || sum_expected.size() > 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed corners under the reset modulus, then phases of
    // random indices under a range of moduli.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] mod_plan [8];
    initial begin
        mod_plan[0] = 64'd2;
        mod_plan[1] = 64'(MOD_MAX);               // largest legal modulus
        mod_plan[2] = 64'd3;
        mod_plan[3] = {13'h1fff, 51'h7ffffffffffff}; // above 2^50, saturates
        mod_plan[4] = 64'd0;                      // degenerate moduli give 0
        mod_plan[5] = 64'd1;
        mod_plan[6] = 64'd1000000007;
        mod_plan[7] = {$urandom(), $urandom()} & 64'h0003ffffffffffff | 64'd2;

        no_gaps    = 1'b0;
        mod_shadow = MOD_RESET;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idx_if.valid = 1'b0;
        idx_if.data  = '0;
        sum_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero index, small indices and bit-pattern extremes
        idx_pending.push_back(32'd0);
        idx_pending.push_back(32'd1);
        idx_pending.push_back(32'd2);
        idx_pending.push_back(32'd3);
        idx_pending.push_back(32'd4);
        idx_pending.push_back(32'd5);
        idx_pending.push_back(32'd17);
        idx_pending.push_back(32'hffffffff);
        idx_pending.push_back(32'h80000000);
        idx_pending.push_back(32'h80000001);
        idx_pending.push_back(32'haaaaaaaa);
        idx_pending.push_back(32'h55555555);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            write_modulus(mod_plan[ph]);
            no_gaps = (ph % 3 == 1);
            idx_pending.push_back(32'd0);
            for (int k = 0; k < 11; k++)
                idx_pending.push_back(rand_index());
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        $display("Covered %0d indices and %0d sums over 9 modulus settings,",
                 idx_beats, sum_beats);
        $display("including saturated and degenerate moduli and a long output hold-off.");
        if (fail_cnt == 0 && sum_expected.size() == 0) begin
            $display("tb_tribonacci_prefix_sum_mod: PASS");
        end else begin
            $display("tb_tribonacci_prefix_sum_mod: FAIL");
        end
        $finish;
    end
endmodule

[sim.f]
src/tpsm_pkg.sv
src/tpsm_stream_if.sv
src/tpsm_mulmod.sv
src/tribonacci_prefix_sum_mod.sv
verif/tb_tribonacci_prefix_sum_mod.sv
